// ===== design/sjsq_pkg.sv =====
// ----------------------------------------------------------------------------
// sjsq_pkg
// Shared types and codes for the shortest-job sorted queue.
// ----------------------------------------------------------------------------
package sjsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 32;
  localparam int TIME_W = 31;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int OUT_OCC_W = 5;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_PEEK   = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_DROPPED   = 2'd1;
  localparam status_t STATUS_EVICTED   = 2'd2;
  localparam status_t STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
  } entry_t;

  typedef struct packed {
    logic              en;
    cmd_t              op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
  } ctrl_t;

endpackage

// ===== design/sjsq_cell.sv =====
// ----------------------------------------------------------------------------
// sjsq_cell
// One queue slot: shifts right on insert, left on remove, else holds.
// ----------------------------------------------------------------------------
module sjsq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sjsq_pkg::ctrl_t  ctrl_i,
  input  sjsq_pkg::entry_t left_i,
  input  sjsq_pkg::entry_t right_i,
  input  logic           left_move_i,
  input  logic           found_i,
  output sjsq_pkg::entry_t entry_o,
  output sjsq_pkg::entry_t entry_nxt_o,
  output logic           move_o,
  output logic           found_o
);
  import sjsq_pkg::*;

  logic              valid_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] tm_r;
  entry_t            cur;
  entry_t            ent_nxt;
  logic              match;

  assign cur     = '{valid: valid_r, id: id_r, tm: tm_r};
  assign match   = valid_r && (id_r == ctrl_i.id);
  assign move_o  = !valid_r || (tm_r > ctrl_i.tm);
  assign found_o = found_i || match;

  always_comb begin
    ent_nxt = cur;
    case (ctrl_i.op)
      CMD_INSERT: begin
        if (move_o) begin
          ent_nxt = left_move_i ? left_i : '{valid: 1'b1, id: ctrl_i.id, tm: ctrl_i.tm};
        end
      end
      CMD_REMOVE: begin
        if (found_o) begin
          ent_nxt = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.en) begin
      id_r <= ent_nxt.id;
      tm_r <= ent_nxt.tm;
    end
  end

  assign entry_o     = cur;
  assign entry_nxt_o = ent_nxt;

endmodule

// ===== design/shortest_job_sorted_queue_unit.sv =====
// ----------------------------------------------------------------------------
// shortest_job_sorted_queue_unit
// Fixed-depth task queue sorted by ascending run time, shortest first.
// ----------------------------------------------------------------------------
// Input word: cmd (insert, remove by id, peek), task_id, task_time.
// Output word: status, head entry after the command, and occupancy.
// Every accepted input word yields exactly one output word.
// The queue is a row of QUEUE_DEPTH slot cells. All cells compare against
// the incoming word in parallel; on insert the cell at the sorted place takes
// the new task and each cell past it takes its left neighbor, on remove each
// cell at or past the first id match takes its right neighbor. The whole
// update lands in all cells at once.
// The output word is registered: it is valid in the cycle after the input word is accepted.
// Throughput: one word per cycle while the receiver does not stall; a new word is taken
// in the same cycle the pending output is taken.
// Reset empties the queue and drops any pending output word.
// When the receiver stalls, the output word holds and in_ready falls
// until it is taken.
// ----------------------------------------------------------------------------
module shortest_job_sorted_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sjsq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [sjsq_pkg::ID_W-1:0]     in_task_id,
  input  logic [sjsq_pkg::TIME_W-1:0]   in_task_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sjsq_pkg::STAT_W-1:0]   out_status,
  output logic                          out_head_valid,
  output logic [sjsq_pkg::ID_W-1:0]     out_head_id,
  output logic [sjsq_pkg::TIME_W-1:0]   out_head_time,
  output logic [sjsq_pkg::OUT_OCC_W-1:0] out_occupancy
);
  import sjsq_pkg::*;

  ctrl_t  ctrl;
  entry_t ent     [QUEUE_DEPTH];
  entry_t ent_nxt [QUEUE_DEPTH];
  entry_t left_e  [QUEUE_DEPTH];
  entry_t right_e [QUEUE_DEPTH];
  logic   move    [QUEUE_DEPTH];
  logic   left_mv [QUEUE_DEPTH];
  logic   fnd_in  [QUEUE_DEPTH];
  logic   fnd_out [QUEUE_DEPTH];

  logic                   accept;
  logic                   full;
  status_t                status_nxt;
  logic [OCC_W-1:0]       occ_r;
  logic [OCC_W-1:0]       occ_nxt;
  logic [OCC_W+OUT_OCC_W-1:0] occ_ext;

  logic                   out_valid_r;
  status_t                status_r;
  logic                   head_valid_r;
  logic [ID_W-1:0]        head_id_r;
  logic [TIME_W-1:0]      head_time_r;
  logic [OUT_OCC_W-1:0]   occupancy_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl = '{en: accept, op: in_cmd, id: in_task_id, tm: in_task_time};

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_e[i]  = '0;
        assign left_mv[i] = 1'b0;
        assign fnd_in[i]  = 1'b0;
      end else begin : g_mid
        assign left_e[i]  = ent[i-1];
        assign left_mv[i] = move[i-1];
        assign fnd_in[i]  = fnd_out[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign right_e[i] = '0;
      end else begin : g_nlast
        assign right_e[i] = ent[i+1];
      end

      sjsq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_i      (ctrl),
        .left_i      (left_e[i]),
        .right_i     (right_e[i]),
        .left_move_i (left_mv[i]),
        .found_i     (fnd_in[i]),
        .entry_o     (ent[i]),
        .entry_nxt_o (ent_nxt[i]),
        .move_o      (move[i]),
        .found_o     (fnd_out[i])
      );
    end
  endgenerate

  assign full = ent[QUEUE_DEPTH-1].valid;

  always_comb begin
    status_nxt = STATUS_OK;
    occ_nxt    = occ_r;
    case (in_cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = move[QUEUE_DEPTH-1] ? STATUS_EVICTED : STATUS_DROPPED;
        end else begin
          occ_nxt = occ_r + OCC_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (fnd_out[QUEUE_DEPTH-1]) begin
          occ_nxt = occ_r - OCC_W'(1);
        end else begin
          status_nxt = STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  assign occ_ext = {{OUT_OCC_W{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r <= occ_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      head_valid_r <= ent_nxt[0].valid;
      head_id_r    <= ent_nxt[0].valid ? ent_nxt[0].id : '0;
      head_time_r  <= ent_nxt[0].valid ? ent_nxt[0].tm : '0;
      occupancy_r  <= occ_ext[OUT_OCC_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_head_valid = head_valid_r;
  assign out_head_id    = head_id_r;
  assign out_head_time  = head_time_r;
  assign out_occupancy  = occupancy_r;

endmodule

// ===== design/sjsq_checker.sv =====
// ----------------------------------------------------------------------------
// sjsq_checker
// Port-level checks for the shortest-job sorted queue.
// ----------------------------------------------------------------------------
module sjsq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sjsq_pkg::STAT_W-1:0]    out_status,
  input logic                           out_head_valid,
  input logic [sjsq_pkg::ID_W-1:0]      out_head_id,
  input logic [sjsq_pkg::TIME_W-1:0]    out_head_time,
  input logic [sjsq_pkg::OUT_OCC_W-1:0] out_occupancy
);
  import sjsq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_head_id) && $stable(out_head_time) && $stable(out_occupancy))
    else $error("output word changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_head_id == '0 && out_head_time == '0 &&
      out_occupancy == '0)
    else $error("empty queue reports nonzero head or occupancy");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_DROPPED || out_status == STATUS_EVICTED)
      |-> out_head_valid)
    else $error("full-queue status with empty head");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind shortest_job_sorted_queue_unit sjsq_checker u_sjsq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_head_valid (out_head_valid),
  .out_head_id    (out_head_id),
  .out_head_time  (out_head_time),
  .out_occupancy  (out_occupancy)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shortest_job_sorted_queue_unit.
// Drives insert, remove, peek and spare-code words with random pauses on both
// sides. A scoreboard keeps its own sorted copy of the queue, derives the
// expected output word for every accepted input word, and checks each output
// word against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
  import sjsq_pkg::*;

  localparam cmd_t              CMD_SPARE    = 2'd3;
  localparam int                LIMIT_CYCLES = 200000;
  localparam int                DRAIN_CYCLES = 8;
  localparam int                RANDOM_WORDS = 700;
  localparam logic [ID_W-1:0]   ID_MAX       = '1;
  localparam logic [TIME_W-1:0] TIME_MAX     = '1;

  typedef struct packed {
    status_t                status;
    logic                   head_valid;
    logic [ID_W-1:0]        head_id;
    logic [TIME_W-1:0]      head_time;
    logic [OUT_OCC_W-1:0]   occupancy;
  } word_t;

  class sjsq_scoreboard;
    logic [ID_W-1:0]   q_id [QUEUE_DEPTH];
    logic [TIME_W-1:0] q_tm [QUEUE_DEPTH];
    int unsigned       fill;
    word_t             pending [$];
    int                errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("tb mismatch: %s", msg);
      errors++;
    endtask

    function status_t do_insert(logic [ID_W-1:0] id, logic [TIME_W-1:0] tm);
      int unsigned pos;
      int unsigned n;
      status_t     st;
      pos = 0;
      n   = fill;
      st  = STATUS_OK;
      while (pos < fill && q_tm[pos] <= tm) pos++;
      if (fill >= QUEUE_DEPTH) begin
        if (pos >= QUEUE_DEPTH) return STATUS_DROPPED;
        st = STATUS_EVICTED;
        n  = QUEUE_DEPTH - 1;
      end
      for (int i = n; i > pos; i--) begin
        q_id[i] = q_id[i-1];
        q_tm[i] = q_tm[i-1];
      end
      q_id[pos] = id;
      q_tm[pos] = tm;
      fill = n + 1;
      return st;
    endfunction

    function status_t do_remove(logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && q_id[i] == id) hit = i;
      end
      if (hit < 0) return STATUS_NOT_FOUND;
      for (int i = hit; i + 1 < fill; i++) begin
        q_id[i] = q_id[i+1];
        q_tm[i] = q_tm[i+1];
      end
      fill--;
      return STATUS_OK;
    endfunction

    function void note_word(cmd_t c, logic [ID_W-1:0] id, logic [TIME_W-1:0] tm);
      word_t w;
      w.status = STATUS_OK;
      case (c)
        CMD_INSERT: w.status = do_insert(id, tm);
        CMD_REMOVE: w.status = do_remove(id);
        default:    w.status = STATUS_OK;
      endcase
      w.head_valid = (fill > 0);
      w.head_id    = (fill > 0) ? q_id[0] : '0;
      w.head_time  = (fill > 0) ? q_tm[0] : '0;
      w.occupancy  = fill[OUT_OCC_W-1:0];
      pending.push_back(w);
    endfunction

    task check_word(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word status=%0d occ=%0d", got.status, got.occupancy));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.head_valid !== want.head_valid)
        report($sformatf("head_valid got %0b want %0b", got.head_valid, want.head_valid));
      if (got.head_id !== want.head_id)
        report($sformatf("head_id got %h want %h", got.head_id, want.head_id));
      if (got.head_time !== want.head_time)
        report($sformatf("head_time got %h want %h", got.head_time, want.head_time));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  cmd_t                  in_cmd;
  logic [ID_W-1:0]       in_task_id;
  logic [TIME_W-1:0]     in_task_time;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  status_t               out_status;
  logic                  out_head_valid;
  logic [ID_W-1:0]       out_head_id;
  logic [TIME_W-1:0]     out_head_time;
  logic [OUT_OCC_W-1:0]  out_occupancy;

  sjsq_scoreboard sb;
  int             src_idle;
  int             dst_idle;
  int unsigned    cycles = 0;

  shortest_job_sorted_queue_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_task_id     (in_task_id),
    .in_task_time   (in_task_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_head_valid (out_head_valid),
    .out_head_id    (out_head_id),
    .out_head_time  (out_head_time),
    .out_occupancy  (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_cmd, in_task_id, in_task_time);
      if (out_valid && out_ready)
        sb.check_word('{out_status, out_head_valid, out_head_id, out_head_time,
                        out_occupancy});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  task send_word(cmd_t c, logic [ID_W-1:0] id, logic [TIME_W-1:0] tm);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_task_id   <= id;
    in_task_time <= tm;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && sb.fill > 0) return sb.q_id[$urandom_range(0, sb.fill - 1)];
    if (r < 6) return ID_W'($urandom_range(0, 7));
    if (r == 6) return ID_MAX;
    if (r == 7) return '0;
    return $urandom;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TIME_MAX;
    if (r < 5) return TIME_W'($urandom_range(0, 15));
    if (r < 7 && sb.fill > 0) return sb.q_tm[$urandom_range(0, sb.fill - 1)];
    return TIME_W'($urandom);
  endfunction

  initial begin
    int unsigned ins_pct;
    int unsigned r;
    cmd_t        c;
    logic [ID_W-1:0] id;

    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_PEEK;
    in_task_id   = '0;
    in_task_time = '0;
    src_idle     = 9;
    dst_idle     = 53;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty queue, extremes, ties, removes at head and middle
    send_word(CMD_PEEK,   '0, '0);
    send_word(CMD_REMOVE, '0, '0);
    send_word(CMD_SPARE,  ID_MAX, TIME_MAX);
    send_word(CMD_INSERT, ID_MAX, TIME_MAX);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, 32'd10, 31'd100);
    send_word(CMD_INSERT, 32'd11, 31'd100);
    send_word(CMD_PEEK,   '0, '0);
    send_word(CMD_REMOVE, 32'd10, '0);
    send_word(CMD_REMOVE, '0, '0);
    send_word(CMD_REMOVE, 32'd12345, '0);
    send_word(CMD_SPARE,  '0, '0);
    // fill to full, then evict and drop
    for (int j = 0; j < QUEUE_DEPTH - 2; j++)
      send_word(CMD_INSERT, 32'd100 + j, 31'd50 + 31'(j * 7));
    send_word(CMD_INSERT, 32'd500, 31'd1);
    send_word(CMD_INSERT, 32'd501, TIME_MAX);
    send_word(CMD_SPARE,  '0, '0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      case (k * 3 / RANDOM_WORDS)
        0:       begin src_idle = 9;  dst_idle = 53; end
        1:       begin src_idle = 53; dst_idle = 9;  end
        default: begin src_idle = 0;  dst_idle = 0;  end
      endcase
      ins_pct = ((k / 60) % 2 == 0) ? 70 : 25;
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        c = CMD_INSERT;
      end else begin
        r = $urandom_range(0, 19);
        c = (r < 15) ? CMD_REMOVE : (r < 18) ? CMD_PEEK : CMD_SPARE;
      end
      if (c == CMD_REMOVE && sb.fill > 0 && $urandom_range(0, 9) < 7)
        id = sb.q_id[$urandom_range(0, sb.fill - 1)];
      else
        id = pick_id();
      send_word(c, id, pick_time());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
